@@ rtl/core/cdd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the calendar day difference unit: field widths, per-stage
// payload types and the small calendar tables. No dependencies.
package cdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 22;
  localparam int DNUM_W  = 23;   // day number of year 16383, Dec 31 fits
  localparam int Q100_W  = 8;    // 16383 / 100 = 163

  localparam int MAX_YEAR = 9999;

  // floor(v / 100) == (v * 5243) >> 19 for every 14-bit v
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + 13;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // First pipeline stage: one date, with its quotients by 100.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  prev;     // year - 1
    logic [Q100_W-1:0]  q_prev;   // (year - 1) / 100
    logic [Q100_W-1:0]  q_year;   // year / 100
    logic [8:0]         cum;      // days before the first of the month
    logic               ym_ok;    // year and month in range
  } cdd_date_t;

  // Second pipeline stage: day number and validity of one date.
  typedef struct packed {
    logic [DNUM_W-1:0] dnum;
    logic              ok;
  } cdd_dnum_t;

  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(RECIP_100);
    return prod[PROD_W-1 -: Q100_W];
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                        r = leap ? 5'd29 : 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/calendar_day_difference_unit.sv @@
`timescale 1ns / 1ps
// Calendar day difference unit: three-stage pipeline that counts the days
// between two Gregorian dates. Depends on cdd_pkg.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid/in_ready, in_later_*, in_earlier_*   | item in
//  out     | out_valid/out_ready, out_day_difference,      | item out
//          | out_order_flag, out_invalid_flag              |
//
// An accepted item is registered in stage 1, then stage 2, then stage 3, whose
// valid bit is out_valid; the result leaves when out_ready is high.
// One item can enter every cycle while the output is not stalled.
// Each stage holds a valid bit and advances when the stage after it is
// empty or moving, so a stall fills the bubbles and then holds everything.
// rst_n (synchronous, active low) clears the valid bits only.
module calendar_day_difference_unit
  import cdd_pkg::*;
#(
  parameter int YEAR_LIMIT = MAX_YEAR   // last year accepted as valid
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DAY_W-1:0]   in_later_day,
  input  logic [MONTH_W-1:0] in_later_month,
  input  logic [YEAR_W-1:0]  in_later_year,
  input  logic [DAY_W-1:0]   in_earlier_day,
  input  logic [MONTH_W-1:0] in_earlier_month,
  input  logic [YEAR_W-1:0]  in_earlier_year,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIFF_W-1:0]  out_day_difference,
  output logic               out_order_flag,
  output logic               out_invalid_flag
);

  // ---------------------------------------------------------------- control
  logic s1_v_r, s2_v_r, s3_v_r;
  logic adv1, adv2, adv3;

  assign adv3     = !s3_v_r || out_ready;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Range checks, year - 1, and the two divisions by 100 (reciprocal multiply).
  function automatic cdd_date_t prep(input logic [DAY_W-1:0]   d,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [YEAR_W-1:0]  y);
    cdd_date_t r;
    r.day    = d;
    r.month  = m;
    r.year   = y;
    r.prev   = y - YEAR_W'(1);
    r.q_prev = div100(y - YEAR_W'(1));
    r.q_year = div100(y);
    r.cum    = cum_days(m);
    r.ym_ok  = (y != '0) && (32'(y) <= YEAR_LIMIT) &&
               (m >= MONTH_JAN) && (m <= MONTH_DEC);
    return r;
  endfunction

  cdd_date_t s1_later_r, s1_later_nxt, s1_earlier_r, s1_earlier_nxt;

  assign s1_later_nxt   = prep(in_later_day, in_later_month, in_later_year);
  assign s1_earlier_nxt = prep(in_earlier_day, in_earlier_month, in_earlier_year);

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_later_r   <= s1_later_nxt;
      s1_earlier_r <= s1_earlier_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Leap rule, day-of-month check and the closed-form day number:
  // 365*p + p/4 - p/100 + p/400 + days before month + day (+1 after Feb
  // in a leap year). p/400 is (p/100)/4.
  function automatic cdd_dnum_t day_num(input cdd_date_t s);
    cdd_dnum_t        r;
    logic [14:0]      cent;
    logic             leap;
    logic [DAY_W-1:0] mlen;
    cent   = 15'(s.q_year) * 15'(100);
    leap   = (s.year[1:0] == 2'b00) &&
             ((15'(s.year) != cent) || (s.q_year[1:0] == 2'b00));
    mlen   = month_len(s.month, leap);
    r.ok   = s.ym_ok && (s.day != '0) && (s.day <= mlen);
    r.dnum = DNUM_W'(s.prev) * DNUM_W'(365)
           + DNUM_W'(s.prev[YEAR_W-1:2])
           - DNUM_W'(s.q_prev)
           + DNUM_W'(s.q_prev[Q100_W-1:2])
           + DNUM_W'(s.cum)
           + DNUM_W'(s.day)
           + DNUM_W'((s.month > MONTH_FEB) && leap);
    return r;
  endfunction

  cdd_dnum_t s2_later_r, s2_later_nxt, s2_earlier_r, s2_earlier_nxt;

  assign s2_later_nxt   = day_num(s1_later_r);
  assign s2_earlier_nxt = day_num(s1_earlier_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_later_r   <= s2_later_nxt;
      s2_earlier_r <= s2_earlier_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Validity check, order compare, subtract, saturate; this register is the output.
  logic [DIFF_W-1:0] diff_r, diff_nxt;
  logic              order_r, order_nxt;
  logic              inval_r, inval_nxt;
  logic [DNUM_W-1:0] raw_diff;

  assign raw_diff = s2_later_r.dnum - s2_earlier_r.dnum;

  always_comb begin
    diff_nxt  = '0;
    order_nxt = 1'b0;
    inval_nxt = 1'b0;
    if (!s2_later_r.ok || !s2_earlier_r.ok) begin
      inval_nxt = 1'b1;
    end else if (s2_later_r.dnum >= s2_earlier_r.dnum) begin
      diff_nxt = raw_diff[DNUM_W-1] ? '1 : raw_diff[DIFF_W-1:0];
    end else begin
      order_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      diff_r  <= diff_nxt;
      order_r <= order_nxt;
      inval_r <= inval_nxt;
    end
  end

  assign out_valid          = s3_v_r;
  assign out_day_difference = diff_r;
  assign out_order_flag     = order_r;
  assign out_invalid_flag   = inval_r;

endmodule

@@ rtl/core/cdd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for calendar_day_difference_unit and its bind.
// Depends on cdd_pkg.
module cdd_checker
  import cdd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIFF_W-1:0] out_day_difference,
  input logic              out_order_flag,
  input logic              out_invalid_flag
);

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_day_difference) && $stable(out_order_flag) &&
      $stable(out_invalid_flag))
    else $error("out item changed while stalled");

  // the pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a bad date yields no count and no order flag
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_flag |->
      out_day_difference == '0 && !out_order_flag)
    else $error("invalid item carries a count or order flag");

  // reversed dates yield no count
  a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order_flag |-> out_day_difference == '0)
    else $error("reversed item carries a count");

endmodule

bind calendar_day_difference_unit cdd_checker u_cdd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_day_difference (out_day_difference),
  .out_order_flag     (out_order_flag),
  .out_invalid_flag   (out_invalid_flag)
);
